/* rtl/vde_pkg.sv */
// Shared types and constants for the int8 vector distance engine.
`timescale 1ns / 1ps
package vde_pkg;

  // Longest vector pair that is summed; later positions flag an overflow
  localparam int MAX_DIM = 16384;
  localparam int POS_W   = $clog2(MAX_DIM + 2);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_DIM);
  localparam logic [POS_W-1:0] POS_SAT   = POS_W'(MAX_DIM + 1);

  // Decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Field widths
  localparam int ELEM_W   = 8;
  localparam int MODE_W   = 3;
  localparam int METRIC_W = 31;
  localparam int SUM_W    = 32;
  localparam int NORM_W   = 29;
  localparam int CMP_W    = 2;
  localparam int STAT_W   = 2;

  // Metric modes
  localparam logic [MODE_W-1:0] MODE_L2     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DOT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NEGDOT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_L1     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COS    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CMP    = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  // Compare outcomes
  localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'b00;
  localparam logic [CMP_W-1:0] CMP_GREATER = 2'b01;
  localparam logic [CMP_W-1:0] CMP_LESS    = 2'b11;

  // Item class decided by the front end
  typedef enum logic [2:0] {
    CLS_EMPTY,
    CLS_OVER,
    CLS_BOTH,
    CLS_ONLY_A,
    CLS_ONLY_B
  } vde_cls_t;

  // Queue entry
  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    vde_cls_t                 cls;
    logic [MODE_W-1:0]        mode;
    logic                     last;
  } vde_item_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic valid;
  } vde_qstat_t;

endpackage

/* rtl/vde_if.sv */
// Channel interfaces: element requests, result requests and mode writes.
`timescale 1ns / 1ps
interface vde_elem_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] a_elem;
  logic signed [7:0] b_elem;
  logic              a_present;
  logic              b_present;
  logic              last;

  modport source (output valid, a_elem, b_elem, a_present, b_present, last, input ready);
  modport sink   (input valid, a_elem, b_elem, a_present, b_present, last, output ready);
endinterface

interface vde_result_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] metric_value;
  logic [28:0]        norm_a_sq;
  logic [28:0]        norm_b_sq;
  logic signed [1:0]  compare_result;
  logic [1:0]         status;

  modport source (output valid, metric_value, norm_a_sq, norm_b_sq, compare_result, status,
                  input ready);
  modport sink   (input valid, metric_value, norm_a_sq, norm_b_sq, compare_result, status,
                  output ready);
endinterface

interface vde_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] metric_mode;

  modport source (output valid, metric_mode, input ready);
  modport sink   (input valid, metric_mode, output ready);
endinterface

/* rtl/vde_front.sv */
// Front end: takes element requests, counts positions, classifies each item.
`timescale 1ns / 1ps
module vde_front (
  input  logic                clk,
  input  logic                rst,
  vde_elem_if.sink            elems,
  vde_cfg_if.sink             cfg,
  input  vde_pkg::vde_qstat_t qstat,
  output logic                push,
  output vde_pkg::vde_item_t  push_item
);
  import vde_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  pos_count;
  logic [POS_W-1:0]  pos_count_next;
  vde_cls_t          cls;

  // Accept while the queue has room; mode writes are always taken
  assign elems.ready = !qstat.full;
  assign cfg.ready   = 1'b1;
  assign push        = elems.valid && !qstat.full;

  // Classify the item against the running position count
  always_comb begin
    if (!elems.a_present && !elems.b_present) begin
      cls = CLS_EMPTY;
    end else if (pos_count >= POS_LIMIT) begin
      cls = CLS_OVER;
    end else if (elems.a_present && elems.b_present) begin
      cls = CLS_BOTH;
    end else if (elems.a_present) begin
      cls = CLS_ONLY_A;
    end else begin
      cls = CLS_ONLY_B;
    end
  end

  assign push_item.a    = elems.a_elem;
  assign push_item.b    = elems.b_elem;
  assign push_item.cls  = cls;
  assign push_item.mode = mode;
  assign push_item.last = elems.last;

  // Advance the position count, saturating past the limit, clear on last
  always_comb begin
    pos_count_next = pos_count;
    if (push) begin
      if (elems.last) begin
        pos_count_next = '0;
      end else begin
        case (cls)
          CLS_EMPTY: pos_count_next = pos_count;
          CLS_OVER:  pos_count_next = POS_SAT;
          default:   pos_count_next = pos_count + 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_L2;
      pos_count <= '0;
    end else begin
      pos_count <= pos_count_next;
      if (cfg.valid) begin
        mode <= cfg.metric_mode;
      end
    end
  end

endmodule

/* rtl/vde_queue.sv */
// Short FIFO that decouples the front end from the accumulator.
`timescale 1ns / 1ps
module vde_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vde_pkg::vde_item_t  push_item,
  input  logic                pop,
  output vde_pkg::vde_item_t  head_item,
  output vde_pkg::vde_qstat_t qstat
);
  import vde_pkg::*;

  vde_item_t         entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_item   = entries[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.valid = (count != '0);

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/vde_back.sv */
// Back end: multiplies, accumulates sums and compare, and holds the result.
`timescale 1ns / 1ps
module vde_back (
  input  logic                clk,
  input  logic                rst,
  input  vde_pkg::vde_qstat_t qstat,
  input  vde_pkg::vde_item_t  item,
  output logic                pop,
  vde_result_if.source        result
);
  import vde_pkg::*;

  logic [SUM_W-1:0]         metric_sum;
  logic [NORM_W-1:0]        norm_a_sum;
  logic [NORM_W-1:0]        norm_b_sum;
  logic                     compare_decided;
  logic [CMP_W-1:0]         compare_value;
  logic [STAT_W-1:0]        error_code;

  logic [SUM_W-1:0]         metric_sum_next;
  logic [NORM_W-1:0]        norm_a_sum_next;
  logic [NORM_W-1:0]        norm_b_sum_next;
  logic                     compare_decided_next;
  logic [CMP_W-1:0]         compare_value_next;
  logic [STAT_W-1:0]        error_code_next;

  logic signed [15:0]       prod_aa;
  logic signed [15:0]       prod_bb;
  logic signed [15:0]       prod_ab;
  logic signed [8:0]        diff;
  logic signed [8:0]        diff_abs;
  logic signed [17:0]       diff_sq;
  logic signed [17:0]       term;
  logic                     distance_mode;

  logic                     out_valid;
  logic signed [METRIC_W-1:0] out_metric;
  logic [NORM_W-1:0]        out_norm_a;
  logic [NORM_W-1:0]        out_norm_b;
  logic [CMP_W-1:0]         out_cmp;
  logic [STAT_W-1:0]        out_status;

  // Take the head item unless it is a last item and the result slot is blocked
  assign pop = qstat.valid && (!item.last || !out_valid || result.ready);

  // Products and differences of this position
  assign prod_aa  = item.a * item.a;
  assign prod_bb  = item.b * item.b;
  assign prod_ab  = item.a * item.b;
  assign diff     = 9'(item.a) - 9'(item.b);
  assign diff_abs = (diff < 0) ? -diff : diff;
  assign diff_sq  = diff * diff;
  assign distance_mode = (item.mode <= MODE_COS);

  // Select the metric term for the item's mode
  always_comb begin
    case (item.mode)
      MODE_L2:     term = diff_sq;
      MODE_DOT:    term = 18'(prod_ab);
      MODE_NEGDOT: term = -18'(prod_ab);
      MODE_L1:     term = 18'(diff_abs);
      MODE_COS:    term = 18'(prod_ab);
      default:     term = '0;
    endcase
  end

  // Fold the item into the running state
  always_comb begin
    metric_sum_next      = metric_sum;
    norm_a_sum_next      = norm_a_sum;
    norm_b_sum_next      = norm_b_sum;
    compare_decided_next = compare_decided;
    compare_value_next   = compare_value;
    error_code_next      = error_code;
    case (item.cls)
      CLS_EMPTY: begin
        if (error_code == ST_OK) error_code_next = ST_EMPTY;
      end
      CLS_OVER: begin
        if (error_code == ST_OK) error_code_next = ST_TOO_MANY;
      end
      CLS_BOTH: begin
        norm_a_sum_next = norm_a_sum + NORM_W'($unsigned(prod_aa));
        norm_b_sum_next = norm_b_sum + NORM_W'($unsigned(prod_bb));
        metric_sum_next = metric_sum + SUM_W'(term);
        if (!compare_decided && (item.a != item.b)) begin
          compare_decided_next = 1'b1;
          compare_value_next   = (item.a < item.b) ? CMP_LESS : CMP_GREATER;
        end
      end
      CLS_ONLY_A: begin
        norm_a_sum_next = norm_a_sum + NORM_W'($unsigned(prod_aa));
        if (distance_mode && (error_code == ST_OK)) error_code_next = ST_MISMATCH;
        if (!compare_decided) begin
          compare_decided_next = 1'b1;
          compare_value_next   = CMP_GREATER;
        end
      end
      CLS_ONLY_B: begin
        norm_b_sum_next = norm_b_sum + NORM_W'($unsigned(prod_bb));
        if (distance_mode && (error_code == ST_OK)) error_code_next = ST_MISMATCH;
        if (!compare_decided) begin
          compare_decided_next = 1'b1;
          compare_value_next   = CMP_LESS;
        end
      end
      default: begin
        error_code_next = error_code;
      end
    endcase
  end

  // Update the running state; clear it once the result is taken out
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_sum      <= '0;
      norm_a_sum      <= '0;
      norm_b_sum      <= '0;
      compare_decided <= 1'b0;
      compare_value   <= CMP_EQUAL;
      error_code      <= ST_OK;
    end else if (pop) begin
      if (item.last) begin
        metric_sum      <= '0;
        norm_a_sum      <= '0;
        norm_b_sum      <= '0;
        compare_decided <= 1'b0;
        compare_value   <= CMP_EQUAL;
        error_code      <= ST_OK;
      end else begin
        metric_sum      <= metric_sum_next;
        norm_a_sum      <= norm_a_sum_next;
        norm_b_sum      <= norm_b_sum_next;
        compare_decided <= compare_decided_next;
        compare_value   <= compare_value_next;
        error_code      <= error_code_next;
      end
    end
  end

  // Hold the result request until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && item.last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      out_metric <= distance_mode ? $signed(metric_sum_next[METRIC_W-1:0]) : '0;
      out_norm_a <= norm_a_sum_next;
      out_norm_b <= norm_b_sum_next;
      out_cmp    <= compare_value_next;
      out_status <= error_code_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.metric_value   = out_metric;
  assign result.norm_a_sq      = out_norm_a;
  assign result.norm_b_sq      = out_norm_b;
  assign result.compare_result = $signed(out_cmp);
  assign result.status         = out_status;

endmodule

/* rtl/int8_vector_distance_engine_core.sv */
// Usage notes:
// The elems channel carries one position of two int8 vectors per request,
// with a presence bit for each vector and a last flag on the final position.
// The cfg channel writes metric_mode (squared L2, dot, negated dot, L1,
// cosine parts, compare only); it is always ready and the mode is sampled
// with each element request, so a change applies from the next request on.
// The result channel gives one request per vector pair: metric, both squared
// norms, the lexicographic compare and a status code.
// Throughput is one element request per cycle while the queue has room.
// With the queue empty, the last element request is written into the queue
// entry when it is accepted, and the accumulator then loads the result
// register from it once the result slot is free, where the sink takes it.
// When the result sink stalls, the accumulator keeps folding non-last items;
// a last item waits in the queue, and elems.ready falls only once the queue
// fills. Reset (rst, synchronous) clears all sums, the queue, the result
// request and sets the mode to squared L2.
`timescale 1ns / 1ps
module int8_vector_distance_engine_core (
  input  logic         clk,
  input  logic         rst,
  vde_cfg_if.sink      cfg,
  vde_elem_if.sink     elems,
  vde_result_if.source result
);
  import vde_pkg::*;

  vde_qstat_t qstat;
  vde_item_t  push_item;
  vde_item_t  head_item;
  logic       push;
  logic       pop;

  // Accept and classify
  vde_front u_front (
    .clk       (clk),
    .rst       (rst),
    .elems     (elems),
    .cfg       (cfg),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple
  vde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // Accumulate and report
  vde_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .item   (head_item),
    .pop    (pop),
    .result (result)
  );

`ifndef SYNTHESIS
  // The accumulator never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.valid)
    else $error("pop from empty queue");

  // The front never pushes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  // A last item is only folded when the result slot frees up
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    (pop && head_item.last) |-> (!result.valid || result.ready))
    else $error("result overwritten");

  // Folding a last item raises a result request on the next cycle
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (pop && head_item.last) |=> result.valid)
    else $error("result request missing");
`endif

endmodule

/* verif/vde_result_checker.sv */
// Result predictor and scoreboard for the int8 vector distance engine.
`timescale 1ns / 1ps
module vde_result_checker (
  input  logic  clk,
  input  logic  rst,
  vde_cfg_if    cfg,
  vde_elem_if   elems,
  vde_result_if result,
  output int    mismatch_count,
  output int    pending_results,
  output int    results_checked
);
  import vde_pkg::*;

  typedef struct {
    logic signed [METRIC_W-1:0] metric;
    logic [NORM_W-1:0]          norm_a;
    logic [NORM_W-1:0]          norm_b;
    logic signed [CMP_W-1:0]    cmp;
    logic [STAT_W-1:0]          status;
  } pair_result_t;

  // Pair results predicted but not yet seen on the result channel
  pair_result_t pair_results_q[$];

  // Predicted engine state
  logic [MODE_W-1:0] mode_r;
  logic [SUM_W-1:0]  metric_acc;
  logic [31:0]       norm_a_acc;
  logic [31:0]       norm_b_acc;
  logic              cmp_done;
  logic [CMP_W-1:0]  cmp_acc;
  int                pos_count;
  logic [STAT_W-1:0] first_error;
  int                errors;
  int                checked;

  function automatic void restart_pair();
    metric_acc  = '0;
    norm_a_acc  = '0;
    norm_b_acc  = '0;
    cmp_done    = 1'b0;
    cmp_acc     = CMP_EQUAL;
    pos_count   = 0;
    first_error = ST_OK;
  endfunction

  // Keep only the first error of a pair
  function automatic void note_error(logic [STAT_W-1:0] code);
    if (first_error == ST_OK) first_error = code;
  endfunction

  function automatic void flag_field(string field, logic signed [31:0] want_v,
                                     logic signed [31:0] seen_v);
    errors++;
    $display("%0t ns: %s expected %0d, got %0d", $time, field, want_v, seen_v);
  endfunction

  always @(posedge clk) begin : predict
    pair_result_t want;
    int           av;
    int           bv;
    int           term;
    logic         is_distance;
    if (rst) begin
      mode_r = MODE_L2;
      restart_pair();
      pair_results_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      // Check a result request against the oldest prediction
      if (result.valid && result.ready) begin
        if (pair_results_q.size() == 0) begin
          errors++;
          $display("%0t ns: result request expected none, got metric %0d status %0d",
                   $time, result.metric_value, result.status);
        end else begin
          want = pair_results_q.pop_front();
          checked++;
          if (result.metric_value !== want.metric)
            flag_field("metric_value", want.metric, result.metric_value);
          if (result.norm_a_sq !== want.norm_a)
            flag_field("norm_a_sq", want.norm_a, result.norm_a_sq);
          if (result.norm_b_sq !== want.norm_b)
            flag_field("norm_b_sq", want.norm_b, result.norm_b_sq);
          if (result.compare_result !== want.cmp)
            flag_field("compare_result", want.cmp, result.compare_result);
          if (result.status !== want.status)
            flag_field("status", want.status, result.status);
        end
      end

      // Track mode writes
      if (cfg.valid && cfg.ready) mode_r = cfg.metric_mode;

      // Fold an element request into the running sums
      if (elems.valid && elems.ready) begin
        av = elems.a_elem;
        bv = elems.b_elem;
        is_distance = (mode_r <= MODE_COS);
        if (!elems.a_present && !elems.b_present) begin
          note_error(ST_EMPTY);
        end else if (pos_count >= MAX_DIM) begin
          note_error(ST_TOO_MANY);
          pos_count = MAX_DIM + 1;
        end else begin
          pos_count++;
          if (elems.a_present) norm_a_acc += av * av;
          if (elems.b_present) norm_b_acc += bv * bv;
          if (elems.a_present && elems.b_present) begin
            case (mode_r)
              MODE_L2:            term = (av - bv) * (av - bv);
              MODE_DOT, MODE_COS: term = av * bv;
              MODE_NEGDOT:        term = -(av * bv);
              MODE_L1:            term = (av > bv) ? av - bv : bv - av;
              default:            term = 0;
            endcase
            metric_acc += term;
            if (!cmp_done && av != bv) begin
              cmp_done = 1'b1;
              cmp_acc  = (av < bv) ? CMP_LESS : CMP_GREATER;
            end
          end else begin
            // One vector ran out: flag in distance modes, decide compare on length
            if (is_distance) note_error(ST_MISMATCH);
            if (!cmp_done) begin
              cmp_done = 1'b1;
              cmp_acc  = elems.a_present ? CMP_GREATER : CMP_LESS;
            end
          end
        end
        if (elems.last) begin
          want.metric = is_distance ? metric_acc[METRIC_W-1:0] : '0;
          want.norm_a = norm_a_acc[NORM_W-1:0];
          want.norm_b = norm_b_acc[NORM_W-1:0];
          want.cmp    = cmp_acc;
          want.status = first_error;
          pair_results_q.push_back(want);
          restart_pair();
        end
      end
    end
    mismatch_count  <= errors;
    pending_results <= pair_results_q.size();
    results_checked <= checked;
  end

endmodule

/* verif/tb_top.sv */
// Top-level testbench: stimulus, result sink, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
  import vde_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_ITEMS  = 130;

  logic clk;
  logic rst;

  vde_cfg_if    cfg_ch ();
  vde_elem_if   elem_ch ();
  vde_result_if res_ch ();

  int mismatch_count;
  int pending_results;
  int results_checked;
  int accepted_elems;
  int snk_wait;
  int quiet_cycles;

  int8_vector_distance_engine_core DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .elems  (elem_ch),
    .result (res_ch)
  );

  vde_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_ch),
    .elems           (elem_ch),
    .result          (res_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  // Free-running clock
  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Draw an element, leaning on the extremes now and then
  function automatic logic signed [ELEM_W-1:0] pick_elem();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h80;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 255));
  endfunction

  // Idle a random stretch, then hold one element request until it is taken
  task automatic send_elem(input logic signed [ELEM_W-1:0] a,
                           input logic signed [ELEM_W-1:0] b,
                           input logic ap, input logic bp, input logic lst);
    int idle;
    idle = $urandom_range(0, 10);
    if (idle > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    elem_ch.valid     <= 1'b1;
    elem_ch.a_elem    <= a;
    elem_ch.b_elem    <= b;
    elem_ch.a_present <= ap;
    elem_ch.b_present <= bp;
    elem_ch.last      <= lst;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    accepted_elems++;
  endtask

  // Drop the element request and wait until every pair has its result
  task automatic quiesce();
    elem_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Write the mode register while nothing is in flight
  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.metric_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int sent;
    int pairs;
    int phase;
    int next_phase;
    int len_a;
    int len_b;
    int positions;
    logic signed [ELEM_W-1:0] av;
    logic signed [ELEM_W-1:0] bv;
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.metric_mode <= '0;
    elem_ch.valid      <= 1'b0;
    elem_ch.a_elem     <= '0;
    elem_ch.b_elem     <= '0;
    elem_ch.a_present  <= 1'b0;
    elem_ch.b_present  <= 1'b0;
    elem_ch.last       <= 1'b0;
    accepted_elems = 0;
    sent       = 0;
    pairs      = 0;
    phase      = 0;
    next_phase = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (sent < RANDOM_ITEMS) begin
      // Step through the mode codes between pairs
      if (sent >= next_phase) begin
        quiesce();
        write_mode(MODE_W'(phase));
        phase++;
        next_phase += PHASE_ITEMS;
      end
      // Shape the pair: mostly equal lengths, some ragged, a few long
      len_a = $urandom_range(0, 12);
      if ($urandom_range(0, 9) < 7) len_b = len_a;
      else len_b = $urandom_range(0, 12);
      if ($urandom_range(0, 19) == 0) begin
        len_a = $urandom_range(60, 120);
        len_b = len_a;
      end
      positions = (len_a > len_b) ? len_a : len_b;
      if (positions == 0) begin
        send_elem(pick_elem(), pick_elem(), 1'b0, 1'b0, 1'b1);
        sent++;
      end else begin
        for (int pos = 0; pos < positions; pos++) begin
          // Slip in an empty position now and then
          if ($urandom_range(0, 19) == 0) begin
            send_elem(pick_elem(), pick_elem(), 1'b0, 1'b0, 1'b0);
            sent++;
          end
          av = pick_elem();
          bv = ($urandom_range(0, 2) == 0) ? av : pick_elem();
          send_elem(av, bv, pos < len_a, pos < len_b, pos == positions - 1);
          sent++;
        end
      end
      pairs++;
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d element requests in %0d vector pairs over %0d mode phases,",
             accepted_elems, pairs, phase);
    $display("with ragged lengths, empty positions and extreme values; %0d results compared.",
             results_checked);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result sink: idle a random stretch per result request
  always @(posedge clk) begin : result_sink
    int draw;
    if (rst) begin
      draw = $urandom_range(0, 10);
      snk_wait     <= draw;
      res_ch.ready <= (draw == 0);
    end else if (res_ch.valid && res_ch.ready) begin
      draw = $urandom_range(0, 10);
      snk_wait     <= draw;
      res_ch.ready <= (draw == 0);
    end else if (res_ch.valid && !res_ch.ready) begin
      snk_wait     <= snk_wait - 1;
      res_ch.ready <= (snk_wait == 1);
    end
  end

  // Watchdog: end the run when nothing is accepted for too long
  always @(posedge clk) begin : watchdog
    if (rst || (elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t ns: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

/* int8_vector_distance_engine_core.f */
rtl/vde_pkg.sv
rtl/vde_if.sv
rtl/vde_front.sv
rtl/vde_queue.sv
rtl/vde_back.sv
rtl/int8_vector_distance_engine_core.sv
verif/vde_result_checker.sv
verif/tb_top.sv
